FILE: hdl/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg - integer stack machine package
// Sizes, command kinds and result status codes shared by the stack machine.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

    localparam int DEPTH     = 64;                    // stack entries
    localparam int CNT_W     = $clog2(DEPTH + 1);     // entry count, holds DEPTH
    localparam int ADDR_W    = $clog2(DEPTH);         // store address
    localparam int MAX_OUT   = 64;                    // words emitted by one print
    localparam int PRK_W     = $clog2(MAX_OUT);       // print word counter
    localparam int KIND_W    = 3;
    localparam int LIT_W     = 31;
    localparam int STATUS_W  = 2;
    localparam int VALUE_W   = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 3'd0,
        KIND_PRINT = 3'd1,
        KIND_SWAP  = 3'd2,
        KIND_DROP  = 3'd3,
        KIND_ADD   = 3'd4,
        KIND_ROLL  = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/ism_if.sv
// ----------------------------------------------------------------------------
// ism_if - stack machine channels
// Command and result channels, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ism_cmd_if
    import ism_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LIT_W-1:0]  literal;

    modport source (output valid, output kind, output literal, input ready);
    modport sink   (input valid, input kind, input literal, output ready);
endinterface

interface ism_res_if
    import ism_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;

    modport source (output valid, output status, output value, output last, input ready);
    modport sink   (input valid, input status, input value, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/integer_stack_machine.sv
// ----------------------------------------------------------------------------
// integer_stack_machine - bounded 32-bit integer stack engine
// Executes push, print, swap, drop, add and roll commands on a RAM-backed stack.
// ----------------------------------------------------------------------------
// Usage:
//  - i_cmd carries one command word (kind, literal); o_res returns result
//    words (status, value, last). A word moves when valid and ready are high.
//  - One command is in flight at a time: i_cmd.ready is high only while the
//    sequencer is idle.
//  - The top of stack lives in a register, the entries below it in a RAM with
//    registered read; every access goes through its single read or write port.
//  - Steps per command: push, drop or short roll of the last entry, errors,
//    empty print and unknown kinds go from execute to the result; swap, add,
//    drop, short roll add a step on the RAM word below the top; roll by n >= 2
//    walks the entries between; print loads the top word, then walks the rest.
//  - The RAM read port paces roll and print walks: read, then write or emit.
//  - Results pass through an output register, so a new command is taken while
//    the last result still waits; a stalled receiver holds the sequencer only
//    when it next has a word to emit.
//  - Reset (synchronous, active low) empties the stack and clears the last
//    literal; the RAM itself is not cleared, entries above the count are never
//    read.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_stack_machine
    import ism_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ism_cmd_if.sink    i_cmd,
    ism_res_if.source  o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LOADTOP,
        S_SWAP,
        S_ADD,
        S_ROLL_M,
        S_ROLL_T,
        S_ROLL_RD,
        S_ROLL_WR,
        S_ROLL_FIN,
        S_EMIT,
        S_PR_TOP,
        S_PR_RD,
        S_PR_OUT
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic [LIT_W-1:0]    r_lit;
    logic [LIT_W-1:0]    r_lastlit;
    logic [CNT_W-1:0]    r_cnt;
    logic [VALUE_W-1:0]  r_top;      // entry cnt-1 when cnt > 0
    logic [VALUE_W-1:0]  r_moved;    // entry carried down by roll
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   r_dst;
    logic [PRK_W-1:0]    r_prk;
    t_status             r_st;

    // output register
    logic                r_ovalid;
    t_status             r_ostatus;
    logic [VALUE_W-1:0]  r_ovalue;
    logic                r_olast;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic                out_free;
    logic                out_load;
    logic [CNT_W-1:0]    cm1, cm2, cm3;
    logic [31:0]         n32;
    logic [31:0]         c32;
    logic [31:0]         dst32;
    logic                roll_short;
    logic                roll_under;
    logic                pr_last;

    assign out_free   = !r_ovalid || o_res.ready;
    // a word goes into the output register this cycle
    assign out_load   = out_free && (r_state == S_EMIT || r_state == S_PR_TOP
                                     || r_state == S_PR_OUT);
    assign cm1        = r_cnt - CNT_W'(1);
    assign cm2        = r_cnt - CNT_W'(2);
    assign cm3        = r_cnt - CNT_W'(3);
    assign n32        = {1'b0, r_lastlit};
    assign c32        = 32'(r_cnt);
    assign dst32      = c32 - 32'd1 - n32;
    assign roll_short = (n32 <= 32'd1);
    assign roll_under = roll_short ? (r_cnt == '0) : (c32 < n32 + 32'd1);
    assign pr_last    = (r_ptr == '0) || (r_prk == PRK_W'(MAX_OUT - 1));

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.status = r_ostatus;
    assign o_res.value  = r_ovalue;
    assign o_res.last   = r_olast;

    ism_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM access per sequencer step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cm1[ADDR_W-1:0];
        ram_wdata = r_top;
        ram_re    = 1'b0;
        ram_raddr = cm2[ADDR_W-1:0];
        case (r_state)
            S_EXEC: begin
                case (r_kind)
                    KIND_PUSH: begin
                        // old top moves into the RAM
                        ram_we = (r_cnt != '0) && (r_cnt != CNT_W'(DEPTH));
                    end
                    KIND_SWAP, KIND_ADD, KIND_DROP: begin
                        ram_re = (r_cnt >= CNT_W'(2));
                    end
                    KIND_ROLL: begin
                        ram_re = !roll_under && (r_cnt >= CNT_W'(2));
                    end
                    default: begin
                    end
                endcase
            end
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = cm2[ADDR_W-1:0];
            end
            S_ROLL_M: begin
                ram_re    = 1'b1;
                ram_raddr = cm3[ADDR_W-1:0];
            end
            S_ROLL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr - ADDR_W'(1);
            end
            S_ROLL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = ram_rdata;
            end
            S_ROLL_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = r_moved;
            end
            S_PR_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr;
            end
            default: begin
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_lastlit <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (o_res.ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_kind  <= t_kind'(i_cmd.kind);
                        r_lit   <= i_cmd.literal;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_kind)
                        KIND_PUSH: begin
                            r_state <= S_EMIT;
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                r_st <= ST_OVER;
                            end else begin
                                r_st      <= ST_OK;
                                r_top     <= {1'b0, r_lit};
                                r_cnt     <= r_cnt + CNT_W'(1);
                                r_lastlit <= r_lit;
                            end
                        end
                        KIND_PRINT: begin
                            if (r_cnt == '0) begin
                                r_st    <= ST_EMPTY;
                                r_state <= S_EMIT;
                            end else begin
                                r_st    <= ST_OK;
                                r_state <= S_PR_TOP;
                            end
                        end
                        KIND_SWAP: begin
                            if (r_cnt < CNT_W'(2)) begin
                                r_st    <= ST_UNDER;
                                r_state <= S_EMIT;
                            end else begin
                                r_st    <= ST_OK;
                                r_state <= S_SWAP;
                            end
                        end
                        KIND_DROP: begin
                            if (r_cnt == '0) begin
                                r_st    <= ST_UNDER;
                                r_state <= S_EMIT;
                            end else begin
                                r_st    <= ST_OK;
                                r_cnt   <= cm1;
                                r_state <= (r_cnt >= CNT_W'(2)) ? S_LOADTOP : S_EMIT;
                            end
                        end
                        KIND_ADD: begin
                            if (r_cnt < CNT_W'(2)) begin
                                r_st    <= ST_UNDER;
                                r_state <= S_EMIT;
                            end else begin
                                r_st    <= ST_OK;
                                r_state <= S_ADD;
                            end
                        end
                        KIND_ROLL: begin
                            if (roll_under) begin
                                r_st    <= ST_UNDER;
                                r_state <= S_EMIT;
                            end else if (roll_short) begin
                                // only the top is popped
                                r_st    <= ST_OK;
                                r_cnt   <= cm1;
                                r_state <= (r_cnt >= CNT_W'(2)) ? S_LOADTOP : S_EMIT;
                            end else begin
                                r_st    <= ST_OK;
                                r_dst   <= dst32[ADDR_W-1:0];
                                r_state <= S_ROLL_M;
                            end
                        end
                        default: begin
                            r_st    <= ST_OK;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_LOADTOP: begin
                    r_top   <= ram_rdata;
                    r_state <= S_EMIT;
                end
                S_SWAP: begin
                    r_top   <= ram_rdata;
                    r_state <= S_EMIT;
                end
                S_ADD: begin
                    r_top   <= ram_rdata + r_top;
                    r_cnt   <= cm1;
                    r_state <= S_EMIT;
                end
                S_ROLL_M: begin
                    r_moved <= ram_rdata;
                    r_state <= S_ROLL_T;
                end
                S_ROLL_T: begin
                    // entry below the moved one becomes the new top
                    r_top <= ram_rdata;
                    r_cnt <= cm1;
                    r_ptr <= cm3[ADDR_W-1:0];
                    if (cm3[ADDR_W-1:0] > r_dst) begin
                        r_state <= S_ROLL_RD;
                    end else begin
                        r_state <= S_ROLL_FIN;
                    end
                end
                S_ROLL_RD: begin
                    r_state <= S_ROLL_WR;
                end
                S_ROLL_WR: begin
                    r_ptr <= r_ptr - ADDR_W'(1);
                    if ({1'b0, r_ptr} > {1'b0, r_dst} + (ADDR_W + 1)'(1)) begin
                        r_state <= S_ROLL_RD;
                    end else begin
                        r_state <= S_ROLL_FIN;
                    end
                end
                S_ROLL_FIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_st;
                        r_ovalue  <= (r_cnt == '0) ? '0 : r_top;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_PR_TOP: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_OK;
                        r_ovalue  <= r_top;
                        r_olast   <= (r_cnt == CNT_W'(1));
                        r_ptr     <= cm2[ADDR_W-1:0];
                        r_prk     <= PRK_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PR_RD;
                        end
                    end
                end
                S_PR_RD: begin
                    r_state <= S_PR_OUT;
                end
                S_PR_OUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_OK;
                        r_ovalue  <= ram_rdata;
                        r_olast   <= pr_last;
                        r_prk     <= r_prk + PRK_W'(1);
                        r_ptr     <= r_ptr - ADDR_W'(1);
                        if (pr_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PR_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while busy");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus == ST_EMPTY) |-> (r_olast && r_ovalue == '0))
        else $error("empty print word malformed");

    a_overflow_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_kind == KIND_PUSH && r_cnt == CNT_W'(DEPTH))
        |=> (r_cnt == CNT_W'(DEPTH) && r_lastlit == $past(r_lastlit)))
        else $error("overflowing push changed state");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_cnt == $past(r_cnt) || r_cnt == CNT_W'($past(r_cnt) + 1'b1)
             || r_cnt == CNT_W'($past(r_cnt) - 1'b1)))
        else $error("entry count jumped");

endmodule

`default_nettype wire

FILE: hdl/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram - generic simple dual-port RAM
// One write port, one read port with registered read data (held when idle).
// ----------------------------------------------------------------------------
`default_nettype none

module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
